[src/blel_pkg.sv]
// Shared types and constants of the bounded integer list engine.
package blel_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 2;
	localparam int LEN_W        = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE     = 3'd4,
		CMD_FIND       = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CMP  = 2'd1,
		S_EXEC = 2'd2
	} state_t;

	// Operation that every cell of the chain performs.
	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_TAKE_LEFT  = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_TAKE_RIGHT = 3'd3,
		OP_CLOSE_GAP  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic              cmp_en;
		logic [DATA_W-1:0] key;
	} cell_ctrl_t;

endpackage

[src/blel_if.sv]
// Request and result channel interfaces of the bounded integer list engine.
interface blel_cmd_if
	import blel_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface blel_res_if
	import blel_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0]  length;

	modport source (output valid, output status, output length, input ready);
	modport sink   (input valid, input status, input length, output ready);
endinterface

[src/bounded_integer_list_engine_unit.sv]
// Top level of the bounded integer list engine: control and the chain of cells.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit integers.
// Requests arrive on cmd_chan (cmd, value) and each one gives exactly one
// result on res_chan (status, length), in request order.
// Commands insert at the front or back, remove the front or back, remove the
// first entry equal to value (later entries move up one place), or find value.
// Every entry sits in its own cell; a command compares all cells against value
// in the compare state and then shifts or loads cells in the update state, each
// shifted cell taking data from its left or right neighbor.
// A request passes through acceptance, the compare state and the update state,
// which writes the result register. The next request is accepted in the cycle
// after the update, so the block takes no new request while one is in work.
// The result register lets a new request be accepted while a result waits; if
// the receiver stalls, the following update waits until the register is free.
// Reset clears the entry count, the control state and the result valid; the
// entry values themselves are not reset and are only compared below the count.
module bounded_integer_list_engine_unit
	import blel_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	blel_cmd_if.sink   cmd_chan,
	blel_res_if.source res_chan
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t            state_q, state_d;
	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] key_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              out_valid_q;
	status_t           out_status_q, status_d;
	logic [LEN_W-1:0]  out_length_q;

	logic              in_fire;
	logic              exec_fire;
	logic              full, empty, found;
	cell_op_t          op_d;
	cell_ctrl_t        ctrl;

	logic [DATA_W-1:0] vals  [CAPACITY];
	logic [CAPACITY:0] chain;

	assign cmd_chan.ready  = (state_q == S_IDLE);
	assign in_fire         = cmd_chan.valid && cmd_chan.ready;
	// The update writes the result register, so it waits for a free slot.
	assign exec_fire       = (state_q == S_EXEC) && (!out_valid_q || res_chan.ready);

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign found = chain[CAPACITY];

	// Decode the held command into the cell operation, status and new count.
	always_comb begin
		op_d     = OP_HOLD;
		status_d = STAT_OK;
		count_d  = count_q;
		unique case (cmd_q)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					op_d    = OP_TAKE_LEFT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					op_d    = OP_PUSH_BACK;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					op_d    = OP_TAKE_RIGHT;
					count_d = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else if (!found) begin
					status_d = STAT_MISSING;
				end else begin
					op_d    = OP_CLOSE_GAP;
					count_d = count_q - 1'b1;
				end
			end
			CMD_FIND: begin
				if (!found) begin
					status_d = STAT_MISSING;
				end
			end
			default: begin
				// Unused codes leave the list alone and report success.
				status_d = STAT_OK;
			end
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_fire) state_d = S_CMP;
			S_CMP:   state_d = S_EXEC;
			S_EXEC:  if (exec_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op     = exec_fire ? op_d : OP_HOLD;
		ctrl.cmp_en = (state_q == S_CMP);
		ctrl.key    = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (res_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd_chan.cmd;
			key_q <= cmd_chan.value;
		end
		if (exec_fire) begin
			out_status_q <= status_d;
			out_length_q <= LEN_W'(count_d);
		end
	end

	assign res_chan.valid  = out_valid_q;
	assign res_chan.status = out_status_q;
	assign res_chan.length = out_length_q;

	// The chain: cell 0 sees the new key on its left, the last cell sees itself
	// on its right, and the first-match flag ripples from front to back.
	assign chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_v, right_v;

		if (i == 0) begin : g_first
			assign left_v = key_q;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end

		blel_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.left      (left_v),
			.right     (right_v),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.value     (vals[i])
		);
	end

endmodule

[src/blel_cell.sv]
// One cell of the list chain: holds one entry and trades it with its neighbors.
module blel_cell
	import blel_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [CNT_W-1:0]  count,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic              chain_in,
	output logic              chain_out,
	output logic [DATA_W-1:0] value
);

	logic [DATA_W-1:0] value_q;
	logic              match_q;
	logic              occupied;

	assign occupied  = CNT_W'(IDX) < count;
	// A cell at or after the first match is part of the gap being closed.
	assign chain_out = chain_in | match_q;
	assign value     = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= occupied && (value_q == ctrl.key);
		end
		unique case (ctrl.op)
			OP_TAKE_LEFT:  value_q <= left;
			OP_PUSH_BACK:  if (CNT_W'(IDX) == count) value_q <= ctrl.key;
			OP_TAKE_RIGHT: value_q <= right;
			OP_CLOSE_GAP:  if (chain_out) value_q <= right;
			default:       value_q <= value_q;
		endcase
	end

endmodule

[src/blel_checker.sv]
// Port-level checks of the bounded integer list engine, bound to the top level.
module blel_checker
	import blel_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [STAT_W-1:0] status,
	input logic [LEN_W-1:0]  length
);

	// A result that is not taken stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request accepted while another is in work");

	// A dropped insert reports a full list.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_FULL |-> length == LEN_W'(CAPACITY))
		else $error("full status with list not full");

	// An empty status reports an empty list.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_EMPTY |-> length == '0)
		else $error("empty status with entries held");

	// The reported length never exceeds the capacity (checked for a capacity up to 31).
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (CAPACITY > 31) || (length <= LEN_W'(CAPACITY)))
		else $error("length beyond capacity");

endmodule

bind bounded_integer_list_engine_unit blel_checker #(.CAPACITY(CAPACITY)) u_blel_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_chan.valid),
	.cmd_ready (cmd_chan.ready),
	.res_valid (res_chan.valid),
	.res_ready (res_chan.ready),
	.status    (res_chan.status),
	.length    (res_chan.length)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the bounded integer list engine: directed table, then random requests.
module tb_top;
	import blel_pkg::*;

	// The testbench keeps its own copy of the list and works out the status and
	// length of every request at the moment the block accepts it. Expected
	// results wait in a queue in request order. A monitor pops one for every
	// result that the block hands over, and compares the result field by field.

	localparam int CAPACITY = CAPACITY_DEF;

	// Command codes that the block does not decode. They must leave the list
	// alone and report the current length with status OK.
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// Phases of the run. Each random phase has its own idle and stall rates.
	localparam int PH_DIRECTED   = 0;
	localparam int PH_FREE       = 1;
	localparam int PH_SEND_IDLE  = 2;
	localparam int PH_RECV_STALL = 3;
	localparam int PH_BOTH       = 4;

	localparam int ITEMS_PER_PHASE  = 188;
	localparam int N_DIRECTED       = 27;
	// At the start of the free-running phase the receiver holds off this long
	// while the sender keeps offering requests, so the block fills and stalls.
	localparam int LONG_HOLD_CYCLES = 80;
	// Margin after the last expected result for a stray one to show up.
	localparam int DRAIN_CYCLES     = 8;
	// Longest quiet stretch of a correct run is the long hold plus a run of
	// random stalls; a much longer stretch with no handshake means a hang.
	localparam int WATCHDOG_LIMIT   = 2000;

	typedef struct {
		status_t          status;
		logic [LEN_W-1:0] length;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] value;
		bit                typed;
		status_t           status;
		logic [LEN_W-1:0]  length;
	} directed_row_t;

	logic clk;
	logic arst_n;

	blel_cmd_if cmd_if ();
	blel_res_if res_if ();

	bounded_integer_list_engine_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_chan(cmd_if),
		.res_chan(res_if)
	);

	// Shadow of the list, front at index 0, and the results still owed by the block.
	logic [DATA_W-1:0] list_shadow[$];
	list_result_t      pending_results[$];
	directed_row_t     directed_rows[N_DIRECTED];

	int mismatch_count = 0;
	int phase_id       = PH_DIRECTED;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	int hold_left      = 0;
	int seen_phase     = PH_DIRECTED;
	// The random stimulus alternates between growing the list to capacity and
	// draining it to empty, so that full and empty lists come up again and again.
	bit growing        = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Applies one request to the shadow list and returns what the block must answer.
	function automatic list_result_t list_apply(input logic [CMD_W-1:0] c,
		input logic [DATA_W-1:0] v);
		list_result_t r;
		int hit;
		int i;
		r.status = STAT_OK;
		hit = -1;
		// Position of the first entry equal to the value, compared on all 32 bits.
		for (i = 0; i < list_shadow.size(); i++) begin
			if (hit < 0 && list_shadow[i] == v) begin
				hit = i;
			end
		end
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (list_shadow.size() >= CAPACITY) begin
					r.status = STAT_FULL;
				end else if (c == CMD_PUSH_FRONT) begin
					list_shadow.push_front(v);
				end else begin
					list_shadow.push_back(v);
				end
			end
			CMD_POP_FRONT: begin
				if (list_shadow.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					void'(list_shadow.pop_front());
				end
			end
			CMD_POP_BACK: begin
				if (list_shadow.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					void'(list_shadow.pop_back());
				end
			end
			CMD_REMOVE: begin
				// Later entries close the gap, which the queue delete does for us.
				if (list_shadow.size() == 0) begin
					r.status = STAT_EMPTY;
				end else if (hit < 0) begin
					r.status = STAT_MISSING;
				end else begin
					list_shadow.delete(hit);
				end
			end
			CMD_FIND: begin
				if (hit < 0) begin
					r.status = STAT_MISSING;
				end
			end
			default: begin
			end
		endcase
		r.length = LEN_W'(list_shadow.size());
		return r;
	endfunction

	// Offers one request, starting and ending at a falling edge. Before it the
	// sender may idle with random junk on the payload. On acceptance the
	// expected result is queued: the typed one for table rows that carry it,
	// otherwise the prediction. The shadow list is updated either way.
	task automatic send_request(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
		input bit typed, input list_result_t typed_result);
		list_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			cmd_if.value <= $urandom;
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.cmd   <= c;
		cmd_if.value <= v;
		@(posedge clk);
		while (!cmd_if.ready) begin
			@(posedge clk);
		end
		predicted = list_apply(c, v);
		pending_results.push_back(typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	// The sender goes quiet until the block has answered every request so far.
	task automatic wait_for_results();
		cmd_if.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stimulus: reset, the directed table, then four random phases.
	initial begin
		list_result_t      typed_result;
		logic [CMD_W-1:0]  c;
		logic [DATA_W-1:0] v;
		int                ph;
		int                n;
		int                row;
		int                roll;

		cmd_if.valid = 1'b0;
		cmd_if.cmd   = CMD_FIND;
		cmd_if.value = '0;
		arst_n       = 1'b0;

		// Rows with typed results: requests on an empty list, an unused code on
		// an empty list, and inserts into a full list. The sixteen inserts in
		// between fill the list with extreme values and repeats; the removals
		// at the end take the first of several equal entries, a missing value,
		// and the back, and a last unused code leaves the list as it is.
		directed_rows = '{
			'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, STAT_EMPTY,   5'd0},
			'{CMD_POP_BACK,   32'hFFFF_FFFF, 1'b1, STAT_EMPTY,   5'd0},
			'{CMD_REMOVE,     32'h0000_0000, 1'b1, STAT_EMPTY,   5'd0},
			'{CMD_FIND,       32'h8000_0000, 1'b1, STAT_MISSING, 5'd0},
			'{CMD_SPARE_6,    32'h1234_5678, 1'b1, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'h8000_0000, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h0000_0001, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h8000_0001, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'h0000_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'hFFFF_0000, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'h1234_5678, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h8765_4321, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, STAT_OK,      5'd0},
			'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, STAT_FULL,    5'd16},
			'{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, STAT_FULL,    5'd16},
			'{CMD_REMOVE,     32'h7FFF_FFFF, 1'b0, STAT_OK,      5'd0},
			'{CMD_REMOVE,     32'hDEAD_BEEF, 1'b0, STAT_OK,      5'd0},
			'{CMD_POP_BACK,   32'h0000_0000, 1'b0, STAT_OK,      5'd0},
			'{CMD_SPARE_7,    32'hFFFF_FFFF, 1'b0, STAT_OK,      5'd0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			typed_result.status = directed_rows[row].status;
			typed_result.length = directed_rows[row].length;
			send_request(directed_rows[row].cmd, directed_rows[row].value,
				directed_rows[row].typed, typed_result);
		end
		wait_for_results();

		for (ph = PH_FREE; ph <= PH_BOTH; ph++) begin
			phase_id       = ph;
			send_idle_pct  = (ph == PH_SEND_IDLE) ? 69 : (ph == PH_BOTH) ? 26 : 0;
			recv_stall_pct = (ph == PH_RECV_STALL) ? 69 : (ph == PH_BOTH) ? 26 : 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Turn around now and then once the list is full or empty, so
				// that full inserts and empty removals also get exercised.
				if (growing && list_shadow.size() == CAPACITY && $urandom_range(3) == 0) begin
					growing = 1'b0;
				end else if (!growing && list_shadow.size() == 0 && $urandom_range(3) == 0) begin
					growing = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll >= 96) begin
					c = roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
				end else if (growing) begin
					c = (roll < 35) ? CMD_PUSH_FRONT :
						(roll < 70) ? CMD_PUSH_BACK :
						(roll < 78) ? CMD_FIND :
						(roll < 86) ? CMD_REMOVE :
						(roll < 91) ? CMD_POP_FRONT : CMD_POP_BACK;
				end else begin
					c = (roll < 28) ? CMD_POP_FRONT :
						(roll < 54) ? CMD_POP_BACK :
						(roll < 76) ? CMD_REMOVE :
						(roll < 84) ? CMD_FIND :
						(roll < 90) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				end
				// Values held in the list make finds and removals hit, and make
				// inserts create duplicates. Small values also collide often.
				case ($urandom_range(4))
					0, 1: begin
						v = (list_shadow.size() != 0) ?
							list_shadow[$urandom_range(list_shadow.size() - 1)] : $urandom;
					end
					2: v = $urandom;
					3: v = $urandom_range(8) - 4;
					default: begin
						case ($urandom_range(3))
							0: v = 32'h8000_0000;
							1: v = 32'h7FFF_FFFF;
							2: v = 32'h0000_0000;
							default: v = 32'hFFFF_FFFF;
						endcase
					end
				endcase
				send_request(c, v, 1'b0, typed_result);
			end
			wait_for_results();
		end

		// Nothing is owed any more; give a stray result the chance to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Receiver: stalls at the rate of the phase, and holds off for a long
	// stretch when the free-running phase begins.
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_id != seen_phase) begin
				seen_phase = phase_id;
				if (phase_id == PH_FREE) begin
					hold_left = LONG_HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Result checker: every accepted result must match the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: status %0d length %0d",
					res_if.status, res_if.length));
			end else begin
				want = pending_results.pop_front();
				if (res_if.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %s",
						res_if.status, want.status.name()));
				end
				if (res_if.length !== want.length) begin
					report_mismatch($sformatf("length %0d, expected %0d",
						res_if.length, want.length));
				end
			end
		end
	end

	// Watchdog: too long without any request or result moving ends the run.
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

endmodule
